FILE: rtl/core/interlace_row_shifter_macros.svh
// Assertion helpers for the row shifter RTL.
`ifndef INTERLACE_ROW_SHIFTER_MACROS_SVH
`define INTERLACE_ROW_SHIFTER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on clk_i, off while rst_ni is low.
`define IRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on clk_i, also during reset.
`define IRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define IRS_ASSERT(lbl, prop, msg)
`define IRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/irs_pkg.sv
package irs_pkg;

  // config port
  localparam int CfgIdxW   = 3;
  localparam int RowWidthW = 12;
  localparam int CfgDataW  = 12;
  localparam int ShiftW    = 8;
  localparam int CompW     = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegEvenShift  = 3'd0,
    RegOddShift   = 3'd1,
    RegRowWidth   = 3'd2,
    RegColorIsYuv = 3'd3,
    RegSixteenBit = 3'd4
  } cfg_reg_e;

  // chroma fill values for YUV
  localparam logic [CompW-1:0] FillMid8  = 16'h0080;
  localparam logic [CompW-1:0] FillMid16 = 16'h8000;

  // control carried alongside the line-store read
  typedef struct packed {
    logic use_fill;
    logic last;
  } rd_meta_t;

endpackage

FILE: rtl/core/irs_ram.sv
module irs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/interlace_row_shifter.sv
// Interlaced row shifter. Takes one pixel item per clock (req_type_i = 0) while
// in_ready_o is high and writes it into one half of a ping-pong line store
// while the same item reads one pixel of the previously completed row from the
// other half, shifted by even_row_shift or odd_row_shift according to that
// row's parity (positive moves right; shifts saturate at +-SHIFT_LIMIT).
// Positions that fall outside the row come out black: components 0 and 3 zero,
// components 1 and 2 zero in RGB or 0x80 / 0x8000 in YUV. Output therefore runs
// one row behind input; a pixel item with no completed row pending gives no
// result. Drain items (req_type_i = 1) read out the rest of the held row after
// input stops, one pixel each, and give nothing when no row is held.
// frame_start_i on a pixel item restarts the column and row parity. Rate: one
// item per cycle while out_ready_i is high; a result passes the registered
// line-store read, then the output register. The line store is a single memory
// of 2*MAX_WIDTH entries of 4*COMPONENT_BITS bits with one write and one read
// per cycle, which is what sets the one-item-per-cycle figure. It has no
// clearing pass after reset: an entry is only read after it was written.
// The user writes configuration only while the block is idle; no check exists.
module interlace_row_shifter
  import irs_pkg::*;
#(
  parameter int MAX_WIDTH      = 2048,
  parameter int SHIFT_LIMIT    = 100,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [CompW-1:0]    in_c0_i,
  input  logic [CompW-1:0]    in_c1_i,
  input  logic [CompW-1:0]    in_c2_i,
  input  logic [CompW-1:0]    in_c3_i,
  input  logic                frame_start_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CompW-1:0]    out_c0_o,
  output logic [CompW-1:0]    out_c1_o,
  output logic [CompW-1:0]    out_c2_o,
  output logic [CompW-1:0]    out_c3_o,
  output logic                last_in_row_o
);

  `include "interlace_row_shifter_macros.svh"

  localparam int CB    = COMPONENT_BITS;
  localparam int DW    = 4 * CB;
  localparam int DEPTH = 2 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLW   = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WW > RowWidthW) ? WW : RowWidthW;  // column / width math
  localparam int SW    = CW + 2;                             // signed source index
  localparam logic [CompW-1:0] CompMask = CompW'((32'd1 << CB) - 32'd1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [ShiftW-1:0] even_shift_q, odd_shift_q;
  logic [RowWidthW-1:0]     row_width_q;
  logic                     color_is_yuv_q, sixteen_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_shift_q   <= '0;
      odd_shift_q    <= '0;
      row_width_q    <= RowWidthW'(2048);
      color_is_yuv_q <= 1'b0;
      sixteen_bit_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegEvenShift:  even_shift_q   <= signed'(cfg_wdata_i[ShiftW-1:0]);
        RegOddShift:   odd_shift_q    <= signed'(cfg_wdata_i[ShiftW-1:0]);
        RegRowWidth:   row_width_q    <= cfg_wdata_i[RowWidthW-1:0];
        RegColorIsYuv: color_is_yuv_q <= cfg_wdata_i[0];
        RegSixteenBit: sixteen_bit_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Row state
  // ---------------------------------------------------------------------------
  logic [CLW-1:0] column_q, column_d;
  logic           row_parity_q, row_parity_d;
  logic           held_valid_q, held_valid_d;
  logic           held_parity_q, held_parity_d;
  logic           write_bank_q, write_bank_d;

  // pipeline: line-store read stage, then output register
  logic     s1_valid_q;
  rd_meta_t s1_meta_q;
  logic     s1_move;
  logic     in_acc;

  logic     out_valid_q;
  logic [CompW-1:0] out_c0_q, out_c1_q, out_c2_q, out_c3_q;
  logic     out_last_q;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;

  // effective width: 0 acts as 1, clipped to MAX_WIDTH
  logic [CW-1:0] rw_ext, eff_w, col_cur, col_clip, emit_col, col_inc;
  logic          is_last, row_par_cur;

  always_comb begin
    rw_ext = CW'(row_width_q);
    if (rw_ext == '0) begin
      eff_w = CW'(1);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
    col_cur  = CW'(column_q);
    col_clip = (col_cur >= eff_w) ? eff_w - CW'(1) : col_cur;
    // a frame start on a pixel item restarts the column; drains ignore it
    emit_col    = (!req_type_i && frame_start_i) ? '0 : col_clip;
    row_par_cur = (!req_type_i && frame_start_i) ? 1'b0 : row_parity_q;
    col_inc     = emit_col + CW'(1);
    is_last     = col_inc >= eff_w;
  end

  // source position in the held row
  logic signed [SW-1:0] sh_ext, sh_clamp, src;
  logic                 src_ok;
  logic [CLW-1:0]       src_idx;

  always_comb begin
    sh_ext = SW'(held_parity_q ? odd_shift_q : even_shift_q);
    if (sh_ext > SW'(SHIFT_LIMIT)) begin
      sh_clamp = SW'(SHIFT_LIMIT);
    end else if (sh_ext < -SW'(SHIFT_LIMIT)) begin
      sh_clamp = -SW'(SHIFT_LIMIT);
    end else begin
      sh_clamp = sh_ext;
    end
    src     = signed'(SW'(emit_col)) - sh_clamp;
    src_ok  = !src[SW-1] && (src[SW-2:0] < (SW-1)'(eff_w));
    src_idx = src[CLW-1:0];
  end

  // next state
  logic emit, do_write;

  always_comb begin
    column_d      = column_q;
    row_parity_d  = row_parity_q;
    held_valid_d  = held_valid_q;
    held_parity_d = held_parity_q;
    write_bank_d  = write_bank_q;
    emit          = 1'b0;
    do_write      = 1'b0;
    if (in_acc) begin
      // every item keeps the column inside the current width
      column_d = CLW'(col_clip);
      if (req_type_i) begin
        if (held_valid_q) begin
          emit         = 1'b1;
          held_valid_d = !is_last;
          column_d     = is_last ? '0 : CLW'(col_inc);
        end
      end else begin
        emit     = held_valid_q;
        do_write = 1'b1;
        if (is_last) begin
          // row complete: it becomes the held row, swap banks
          held_valid_d  = 1'b1;
          held_parity_d = row_par_cur;
          write_bank_d  = !write_bank_q;
          row_parity_d  = !row_par_cur;
          column_d      = '0;
        end else begin
          row_parity_d = row_par_cur;
          column_d     = CLW'(col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= '0;
      row_parity_q  <= 1'b0;
      held_valid_q  <= 1'b0;
      held_parity_q <= 1'b0;
      write_bank_q  <= 1'b0;
    end else begin
      column_q      <= column_d;
      row_parity_q  <= row_parity_d;
      held_valid_q  <= held_valid_d;
      held_parity_q <= held_parity_d;
      write_bank_q  <= write_bank_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: bank 0 at [0, MAX_WIDTH), bank 1 above it
  // ---------------------------------------------------------------------------
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  assign waddr = AW'(emit_col[CLW-1:0]) + (write_bank_q ? AW'(MAX_WIDTH) : '0);
  assign raddr = AW'(src_idx) + (write_bank_q ? '0 : AW'(MAX_WIDTH));
  assign wdata = {in_c3_i[CB-1:0], in_c2_i[CB-1:0], in_c1_i[CB-1:0], in_c0_i[CB-1:0]};

  irs_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (emit && src_ok),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // read stage: tracks the item whose line-store data is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      s1_meta_q.use_fill <= !src_ok;
      s1_meta_q.last     <= is_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [CompW-1:0] fill_mid;

  assign fill_mid = color_is_yuv_q ? ((sixteen_bit_q ? FillMid16 : FillMid8) & CompMask)
                                   : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_last_q <= s1_meta_q.last;
      if (s1_meta_q.use_fill) begin
        out_c0_q <= '0;
        out_c1_q <= fill_mid;
        out_c2_q <= fill_mid;
        out_c3_q <= '0;
      end else begin
        out_c0_q <= CompW'(rdata[0*CB +: CB]);
        out_c1_q <= CompW'(rdata[1*CB +: CB]);
        out_c2_q <= CompW'(rdata[2*CB +: CB]);
        out_c3_q <= CompW'(rdata[3*CB +: CB]);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_c0_o      = out_c0_q;
  assign out_c1_o      = out_c1_q;
  assign out_c2_o      = out_c2_q;
  assign out_c3_o      = out_c3_q;
  assign last_in_row_o = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IRS_ASSERT(a_held_fall_on_item, $fell(held_valid_q) |-> $past(in_acc), "held row dropped without an item")
  `IRS_ASSERT(a_bank_swap_on_pixel, !$stable(write_bank_q) |-> $past(in_acc && !req_type_i && is_last), "bank swap outside row end")
  `IRS_ASSERT(a_emit_reaches_s1, (in_acc && emit) |=> s1_valid_q, "emitted item lost before read stage")
  `IRS_ASSERT(a_s1_holds, (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_meta_q)), "read stage changed while stalled")
  `IRS_ASSERT_ALWAYS(a_no_accept_when_full, (s1_valid_q && !s1_move) |-> !in_ready_o, "input taken while read stage blocked")

endmodule
